// File: hdl/kott_pkg.sv
// ----------------------------------------------------------------------------
// kott_pkg
// Shared types and constants for the keyed one-shot timer table.
// ----------------------------------------------------------------------------
package kott_pkg;

    // default table depth
    localparam int KOTT_MAX_TIMERS = 16;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture a new request, read entry 0
        logic step;    // retire the current entry, read the next one
        logic take;    // start hit: reload the matching entry
        logic finish;  // write back counts, emit the closing word
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic n_zero;    // table empty
        logic at_last;   // current entry is the last live one
        logic is_tick;   // request is a tick
        logic hit;       // tick: entry expired; start: id matches
        logic pend;      // an expired id waits to be reported
        logic out_free;  // output register can take a word
    } t_dp_sts;

endpackage

// File: hdl/kott_ctrl.sv
// ----------------------------------------------------------------------------
// kott_ctrl
// Sequencer for the timer table: accept, walk the live entries, close.
// ----------------------------------------------------------------------------
module kott_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  kott_pkg::t_dp_sts i_sts,
    output kott_pkg::t_dp_cmd o_cmd,
    output logic              o_in_stall
);

    kott_pkg::t_state r_state;
    kott_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kott_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kott_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.n_zero ? kott_pkg::ST_FIN : kott_pkg::ST_SCAN;
                end
            end
            kott_pkg::ST_SCAN: begin
                if (o_cmd.take) begin
                    n_state = kott_pkg::ST_FIN;
                end else if (o_cmd.step && i_sts.at_last) begin
                    n_state = kott_pkg::ST_FIN;
                end
            end
            kott_pkg::ST_FIN: begin
                if (i_sts.out_free) begin
                    n_state = kott_pkg::ST_IDLE;
                end
            end
            default: n_state = kott_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            kott_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            kott_pkg::ST_SCAN: begin
                if (i_sts.is_tick) begin
                    // hold when a pending id must go out and the output is busy
                    o_cmd.step = !(i_sts.hit && i_sts.pend && !i_sts.out_free);
                end else if (i_sts.hit) begin
                    o_cmd.take = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            kott_pkg::ST_FIN: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/kott_dp.sv
// ----------------------------------------------------------------------------
// kott_dp
// Timer table storage, request registers, compaction and output register.
// ----------------------------------------------------------------------------
module kott_dp #(
    parameter int MAX_TIMERS = kott_pkg::KOTT_MAX_TIMERS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kott_pkg::t_dp_cmd  i_cmd,
    output kott_pkg::t_dp_sts  o_sts,
    input  logic               i_req_type,
    input  logic [7:0]         i_timer_id,
    input  logic signed [31:0] i_duration,
    input  logic [15:0]        i_elapsed_ticks,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_expired_valid,
    output logic [7:0]         o_expired_id,
    output logic               o_table_full,
    output logic               o_last
);

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);

    // table storage
    logic [7:0]         r_mem_id  [MAX_TIMERS];
    logic signed [31:0] r_mem_rem [MAX_TIMERS];
    logic [7:0]         r_rd_id;
    logic signed [31:0] r_rd_rem;

    logic [IDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_w;
    logic [CNT_W-1:0]   r_live;

    logic               r_req_tick;
    logic [7:0]         r_req_id;
    logic signed [31:0] r_req_dur;
    logic [15:0]        r_req_elapsed;
    logic               r_pend;
    logic [7:0]         r_pend_id;
    logic               r_found;

    logic               r_out_valid;
    logic               r_out_exp;
    logic [7:0]         r_out_id;
    logic               r_out_full;
    logic               r_out_last;

    logic signed [32:0] diff;
    logic               expired;
    logic               match;
    logic               hit;
    logic               at_last;
    logic               room;
    logic               out_free;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [7:0]         wr_id;
    logic signed [31:0] wr_rem;
    logic               emit_prev;
    logic               emit;

    // survivors never saturate: a clamped value is negative and expires
    assign diff     = {r_rd_rem[31], r_rd_rem} - $signed({17'd0, r_req_elapsed});
    assign expired  = diff[32] || (diff == 33'sd0);
    assign match    = (r_rd_id == r_req_id);
    assign hit      = r_req_tick ? expired : match;
    assign at_last  = (CNT_W'(r_idx) + CNT_W'(1)) == r_live;
    assign room     = (r_live != CNT_W'(MAX_TIMERS));
    assign out_free = !r_out_valid || !i_out_stall;

    assign rd_en   = i_cmd.load || i_cmd.step;
    assign rd_addr = i_cmd.load ? '0 : r_idx + 1'b1;

    assign emit_prev = i_cmd.step && r_req_tick && expired && r_pend;
    assign emit      = emit_prev || i_cmd.finish;

    // single write port: compaction, reload in place or append
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_id   = r_req_id;
        wr_rem  = r_req_dur;
        if (i_cmd.step && r_req_tick && !expired) begin
            wr_en   = 1'b1;
            wr_addr = r_w[IDX_W-1:0];
            wr_id   = r_rd_id;
            wr_rem  = diff[31:0];
        end else if (i_cmd.take) begin
            wr_en   = 1'b1;
            wr_addr = r_idx;
        end else if (i_cmd.finish && !r_req_tick && !r_found && room) begin
            wr_en   = 1'b1;
            wr_addr = r_live[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_id[wr_addr]  <= wr_id;
            r_mem_rem[wr_addr] <= wr_rem;
        end
        if (rd_en) begin
            r_rd_id  <= r_mem_id[rd_addr];
            r_rd_rem <= r_mem_rem[rd_addr];
        end
    end

    // request capture and walk counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_tick    <= (i_req_type == kott_pkg::REQ_TICK);
            r_req_id      <= i_timer_id;
            r_req_dur     <= i_duration;
            r_req_elapsed <= i_elapsed_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_w       <= '0;
            r_live    <= '0;
            r_pend    <= 1'b0;
            r_pend_id <= '0;
            r_found   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_w     <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
                if (r_req_tick) begin
                    if (expired) begin
                        r_pend    <= 1'b1;
                        r_pend_id <= r_rd_id;
                    end else begin
                        r_w <= r_w + 1'b1;
                    end
                end
            end
            if (i_cmd.take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.finish) begin
                if (r_req_tick) begin
                    r_live <= r_w;
                end else if (!r_found && room) begin
                    r_live <= r_live + 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_prev) begin
            r_out_exp  <= 1'b1;
            r_out_id   <= r_pend_id;
            r_out_full <= 1'b0;
            r_out_last <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_exp  <= r_req_tick && r_pend;
            r_out_id   <= (r_req_tick && r_pend) ? r_pend_id : 8'd0;
            r_out_full <= !r_req_tick && !r_found && !room;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_expired_valid = r_out_exp;
    assign o_expired_id    = r_out_id;
    assign o_table_full    = r_out_full;
    assign o_last          = r_out_last;

    assign o_sts.n_zero   = (r_live == '0);
    assign o_sts.at_last  = at_last;
    assign o_sts.is_tick  = r_req_tick;
    assign o_sts.hit      = hit;
    assign o_sts.pend     = r_pend;
    assign o_sts.out_free = out_free;

endmodule

// File: hdl/keyed_oneshot_timer_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_oneshot_timer_table_unit
// Table of one-shot countdown timers keyed by an 8-bit id, in insertion order.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                  | word contents
//   --------+-----------+----------------------------+---------------------------------
//   in      | to block  | i_in_valid / o_in_stall    | req_type, timer_id, duration,
//           |           |                            | elapsed_ticks
//   out     | from block| o_out_valid / i_out_stall  | expired_valid, expired_id,
//           |           |                            | table_full, last
//
// Sequence: a request is accepted, then the live entries are walked one by one
//   through the table (single read / single write memory port), then the
//   request closes. A start that hits its id stops the walk at that entry.
// Reset: synchronous, active low; clears the live count and control state.
//   Table contents are not cleared, only entries below the live count are read.
// Stalls: an output stall holds the walk only when a second expired id needs
//   the output register; the closing word waits in place for a free slot.
// ----------------------------------------------------------------------------
module keyed_oneshot_timer_table_unit #(
    parameter int MAX_TIMERS = kott_pkg::KOTT_MAX_TIMERS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request words
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [7:0]         i_timer_id,
    input  logic signed [31:0] i_duration,
    input  logic [15:0]        i_elapsed_ticks,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_expired_valid,
    output logic [7:0]         o_expired_id,
    output logic               o_table_full,
    output logic               o_last
);

    kott_pkg::t_dp_cmd cmd;
    kott_pkg::t_dp_sts sts;

    // sequencer: accept, walk, close
    kott_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // table memory, compaction and result register
    kott_dp #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_req_type      (i_req_type),
        .i_timer_id      (i_timer_id),
        .i_duration      (i_duration),
        .i_elapsed_ticks (i_elapsed_ticks),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_expired_valid (o_expired_valid),
        .o_expired_id    (o_expired_id),
        .o_table_full    (o_table_full),
        .o_last          (o_last)
    );

endmodule

// File: hdl/kott_chk.sv
// ----------------------------------------------------------------------------
// kott_chk
// Port-level checks for the timer table, bound to the top level.
// ----------------------------------------------------------------------------
module kott_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_expired_valid,
    input logic [7:0]  o_expired_id,
    input logic        o_table_full,
    input logic        o_last
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_expired_valid) && $stable(o_expired_id)
            && $stable(o_table_full) && $stable(o_last))
        else $error("result word changed under stall");

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while previous still in work");

    // a dropped start closes its request and reports no expiry
    a_full_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_full |-> o_last && !o_expired_valid)
        else $error("table full flag on a non-final or expiry word");

    // words without an expiry carry id zero
    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_expired_valid |-> o_expired_id == 8'd0)
        else $error("nonzero id on a word without expiry");

    // no result word straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind keyed_oneshot_timer_table_unit kott_chk u_kott_chk (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed one-shot timer table.
// A scoreboard class keeps its own copy of the timer table and queues the
// result words that each accepted request must produce. A task drives requests
// with random idle gaps while a receiver process applies random stalls and
// checks each result word against the oldest queued expectation.
// ----------------------------------------------------------------------------
module testbench;

    localparam int    RANDOM_ITEMS = 500;
    localparam int    CYCLE_LIMIT  = 1_000_000;
    // longest walk of the table plus the closing word, with margin
    localparam int    DRAIN_CYCLES = 2 * (kott_pkg::KOTT_MAX_TIMERS + 2);
    localparam int    REPORT_MAX   = 10;
    // remaining time saturates here
    localparam longint LEFT_FLOOR  = -64'sd2147483648;

    typedef struct packed {
        logic       expired_valid;
        logic [7:0] expired_id;
        logic       table_full;
        logic       last;
    } t_result_word;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow timer table plus the queue of expected result words.
    // ------------------------------------------------------------------------
    class timer_table_scoreboard;
        logic [7:0]         timer_ids   [kott_pkg::KOTT_MAX_TIMERS];
        logic signed [31:0] timers_left [kott_pkg::KOTT_MAX_TIMERS];
        int                 live_timers;
        t_result_word       expected_words [$];
        int                 failures;

        function new();
            live_timers = 0;
            failures    = 0;
        endfunction

        // Apply one accepted request to the shadow table and queue its words.
        function void note_request(logic req, logic [7:0] id,
                                   logic signed [31:0] dur, logic [15:0] elapsed);
            t_result_word w;
            logic [7:0]   gone [$];
            longint       t;
            int           keep;
            bit           found;
            found  = 1'b0;
            keep   = 0;
            w      = '0;
            w.last = 1'b1;
            if (req == kott_pkg::REQ_START) begin
                for (int i = 0; i < live_timers; i++) begin
                    if (!found && timer_ids[i] == id) begin
                        timers_left[i] = dur;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    if (live_timers < kott_pkg::KOTT_MAX_TIMERS) begin
                        timer_ids[live_timers]   = id;
                        timers_left[live_timers] = dur;
                        live_timers++;
                    end else begin
                        w.table_full = 1'b1;
                    end
                end
                expected_words.push_back(w);
            end else begin
                // count down every live timer, compact the survivors in order
                for (int i = 0; i < live_timers; i++) begin
                    t = longint'(timers_left[i]) - longint'(elapsed);
                    if (t < LEFT_FLOOR) t = LEFT_FLOOR;
                    if (t <= 0) begin
                        gone.push_back(timer_ids[i]);
                    end else begin
                        timer_ids[keep]   = timer_ids[i];
                        timers_left[keep] = t[31:0];
                        keep++;
                    end
                end
                live_timers = keep;
                if (gone.size() == 0) begin
                    expected_words.push_back(w);
                end else begin
                    foreach (gone[k]) begin
                        w.expired_valid = 1'b1;
                        w.expired_id    = gone[k];
                        w.last          = (k == gone.size() - 1);
                        expected_words.push_back(w);
                    end
                end
            end
        endfunction

        // Compare one accepted result word with the oldest expectation.
        function void check_word(t_result_word got);
            t_result_word want;
            if (expected_words.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display({"result word with nothing expected: ",
                              "valid=%0b id=%02h full=%0b last=%0b"},
                             got.expired_valid, got.expired_id, got.table_full,
                             got.last);
                return;
            end
            want = expected_words.pop_front();
            if (got.expired_valid !== want.expired_valid ||
                got.expired_id    !== want.expired_id    ||
                got.table_full    !== want.table_full    ||
                got.last          !== want.last) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display({"mismatch: expected valid=%0b id=%02h full=%0b last=%0b, ",
                              "got valid=%0b id=%02h full=%0b last=%0b"},
                             want.expired_valid, want.expired_id, want.table_full,
                             want.last,
                             got.expired_valid, got.expired_id, got.table_full,
                             got.last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_in_valid      = 1'b0;
    logic               o_in_stall;
    logic               i_req_type      = kott_pkg::REQ_START;
    logic [7:0]         i_timer_id      = '0;
    logic signed [31:0] i_duration      = '0;
    logic [15:0]        i_elapsed_ticks = '0;
    logic               o_out_valid;
    logic               i_out_stall     = 1'b0;
    logic               o_expired_valid;
    logic [7:0]         o_expired_id;
    logic               o_table_full;
    logic               o_last;

    timer_table_scoreboard timer_sb = new();

    // idle switches, redrawn per stretch so that some stretches run back to back
    bit in_idle  = 1'b1;
    bit out_idle = 1'b1;
    int cycle_count = 0;

    always #5 i_clk = ~i_clk;

    keyed_oneshot_timer_table_unit #(
        .MAX_TIMERS      (kott_pkg::KOTT_MAX_TIMERS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_timer_id      (i_timer_id),
        .i_duration      (i_duration),
        .i_elapsed_ticks (i_elapsed_ticks),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_expired_valid (o_expired_valid),
        .o_expired_id    (o_expired_id),
        .o_table_full    (o_table_full),
        .o_last          (o_last)
    );

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("keyed_oneshot_timer_table_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Idle for a random gap, then hold the word until it is accepted. The
    // stall is sampled on the falling edge, where inputs and outputs are
    // settled, and the word is taken on the next rising edge.
    task automatic send_request(logic req, logic [7:0] id,
                                logic signed [31:0] dur, logic [15:0] elapsed);
        int gap;
        bit taken;
        gap = in_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_timer_id      <= id;
        i_duration      <= dur;
        i_elapsed_ticks <= elapsed;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        timer_sb.note_request(req, id, dur, elapsed);
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall a random number of cycles before each word.
    // ------------------------------------------------------------------------
    task automatic receive_words();
        int           hold;
        int           words;
        bit           taken;
        t_result_word got;
        words = 0;
        forever begin
            if (words % 40 == 0) out_idle = $urandom_range(0, 3) != 0;
            hold = out_idle ? $urandom_range(0, 19) : 0;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                taken = o_out_valid && !i_out_stall;
                got   = '{o_expired_valid, o_expired_id, o_table_full, o_last};
                @(posedge i_clk);
            end while (!taken);
            timer_sb.check_word(got);
            words++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int                 start_pct;
        bit                 narrow_ids;
        logic               req;
        logic [7:0]         id;
        logic signed [31:0] dur;
        logic [15:0]        elapsed;
        start_pct  = 60;
        narrow_ids = 1'b1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        fork
            receive_words();
        join_none

        // Directed part. Ticks on an empty table, with no and with the
        // largest elapsed count.
        send_request(kott_pkg::REQ_TICK, 8'h00, 32'sh0000_0000, 16'h0000);
        send_request(kott_pkg::REQ_TICK, 8'hFF, 32'shFFFF_FFFF, 16'hFFFF);
        // Extreme durations and ids, a zero and a one-tick timer.
        send_request(kott_pkg::REQ_START, 8'h00, 32'sh8000_0000, 16'h0000);
        send_request(kott_pkg::REQ_START, 8'hFF, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(kott_pkg::REQ_START, 8'h5A, 32'sh0000_0000, 16'h0000);
        send_request(kott_pkg::REQ_START, 8'hA5, 32'sh0000_0001, 16'h0000);
        // Reload a live id in place.
        send_request(kott_pkg::REQ_START, 8'h00, 32'sd100, 16'h0000);
        // A zero-length tick still expires the zero-duration timer.
        send_request(kott_pkg::REQ_TICK, 8'h00, 32'sh0000_0000, 16'h0000);
        send_request(kott_pkg::REQ_TICK, 8'h00, 32'sh0000_0000, 16'h0001);
        // Near the floor: the next big tick must saturate, not wrap.
        send_request(kott_pkg::REQ_START, 8'h33, -32'sd2147483000, 16'h0000);
        send_request(kott_pkg::REQ_TICK, 8'h00, 32'sh0000_0000, 16'hFFFF);
        // Fill the table, then overflow it and reload while full.
        for (int i = 0; i < kott_pkg::KOTT_MAX_TIMERS - 1; i++)
            send_request(kott_pkg::REQ_START, 8'h10 + 8'(i), 32'sd1000 + i, 16'h0000);
        send_request(kott_pkg::REQ_START, 8'hEE, 32'sd5, 16'h0000);
        send_request(kott_pkg::REQ_START, 8'h12, 32'sd3, 16'h0000);
        // Expire entries scattered through the table, then nearly all.
        send_request(kott_pkg::REQ_TICK, 8'h00, 32'sh0000_0000, 16'd1000);
        send_request(kott_pkg::REQ_TICK, 8'h00, 32'sh0000_0000, 16'hFFFF);

        // Random part: stretches with their own start rate, id spread and idling.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                start_pct  = $urandom_range(35, 85);
                narrow_ids = $urandom_range(0, 2) != 0;
                in_idle    = $urandom_range(0, 3) != 0;
            end
            req = ($urandom_range(1, 100) <= start_pct) ? kott_pkg::REQ_START
                                                        : kott_pkg::REQ_TICK;
            id  = narrow_ids ? 8'($urandom_range(0, 23)) : 8'($urandom);
            case ($urandom_range(0, 9))
                0: begin
                    dur = -$signed(32'($urandom_range(0, 50)));
                end
                1: begin
                    dur = $urandom;
                end
                2: begin
                    dur = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 9)
                                               : 32'h8000_0000 + $urandom_range(0, 9);
                end
                default: begin
                    dur = $urandom_range(1, 3000);
                end
            endcase
            case ($urandom_range(0, 7))
                0: begin
                    elapsed = 16'h0000;
                end
                1: begin
                    elapsed = 16'($urandom_range(0, 65535));
                end
                default: begin
                    elapsed = 16'($urandom_range(1, 400));
                end
            endcase
            send_request(req, id, dur, elapsed);
        end
        i_in_valid <= 1'b0;

        // Drain outstanding words, then give stray words time to show up.
        while (timer_sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (timer_sb.failures == 0 && timer_sb.expected_words.size() == 0) begin
            $display("keyed_oneshot_timer_table_unit test passed");
        end else begin
            $display("keyed_oneshot_timer_table_unit test failed");
        end
        $finish;
    end

endmodule

// File: keyed_oneshot_timer_table_unit.f
hdl/kott_pkg.sv
hdl/kott_ctrl.sv
hdl/kott_dp.sv
hdl/keyed_oneshot_timer_table_unit.sv
hdl/kott_chk.sv
sim/testbench.sv
